@@ hdl/shared_pool_multi_stack_top_assert.svh @@
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_top_assert
// Assertion macros for the shared pool stack block. Clock clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SHARED_POOL_MULTI_STACK_TOP_ASSERT_SVH
`define SHARED_POOL_MULTI_STACK_TOP_ASSERT_SVH

// condition holds at every edge
`define SPMS_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent holds in the same cycle
`define SPMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define SPMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/spms_pkg.sv @@
// ----------------------------------------------------------------------------
// spms_pkg
// Types, sizes and codes shared by the shared pool stack modules.
// ----------------------------------------------------------------------------
package spms_pkg;

  localparam int POOL_CELLS = 256;
  localparam int VALUE_BITS = 32;
  localparam int IO_BITS    = 32;
  localparam int NUM_STACKS = 3;
  localparam int CELL_BITS  = $clog2(POOL_CELLS);
  localparam int TOP_BITS   = CELL_BITS + 1;
  localparam int COUNT_BITS = $clog2(POOL_CELLS + 1);

  localparam logic [TOP_BITS-1:0] NO_CELL = TOP_BITS'(POOL_CELLS);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } stat_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    kind_t                     kind;
    logic [1:0]                stack_select;
    logic signed [IO_BITS-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    stat_t                     status;
    logic signed [IO_BITS-1:0] read_value;
    logic                      empty_flag;
  } out_word_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 take;
    logic                 give;
    logic [CELL_BITS-1:0] give_cell;
  } ring_req_t;

  typedef struct packed {
    logic [CELL_BITS-1:0] cell_idx;
    logic                 empty;
    logic                 full;
  } ring_stat_t;

endpackage

@@ hdl/spms_ram.sv @@
// ----------------------------------------------------------------------------
// spms_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/spms_free_ring.sv @@
// ----------------------------------------------------------------------------
// spms_free_ring
// FIFO ring of free cell indices with head, tail and fill count.
// ----------------------------------------------------------------------------
module spms_free_ring (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spms_pkg::ring_req_t    ring_req,
  output spms_pkg::ring_stat_t   ring_stat
);

  localparam int CB = spms_pkg::CELL_BITS;

  logic [CB-1:0]                   head_r, head_nxt;
  logic [CB-1:0]                   tail_r, tail_nxt;
  logic [spms_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [spms_pkg::POOL_CELLS-1:0] vld_r;
  logic                            rd_vld_r;
  logic [CB-1:0]                   rd_idx_r;
  logic [CB-1:0]                   ram_q;

  function automatic logic [CB-1:0] ring_next(input logic [CB-1:0] i);
    ring_next = (i == CB'(spms_pkg::POOL_CELLS - 1)) ? '0 : i + 1'b1;
  endfunction

  spms_ram #(
    .WIDTH (CB),
    .DEPTH (spms_pkg::POOL_CELLS)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_req.give),
    .wr_addr (tail_r),
    .wr_data (ring_req.give_cell),
    .rd_en   (ring_req.rd_en),
    .rd_addr (head_r),
    .rd_data (ram_q)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ring_req.take) begin
      head_nxt  = ring_next(head_r);
      count_nxt = count_r - 1'b1;
    end
    if (ring_req.give) begin
      tail_nxt  = ring_next(tail_r);
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= spms_pkg::COUNT_BITS'(spms_pkg::POOL_CELLS);
      vld_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (ring_req.give) begin
        vld_r[tail_r] <= 1'b1;
      end
    end
  end

  // unwritten slot reads as its own index
  always_ff @(posedge clk) begin
    if (ring_req.rd_en) begin
      rd_vld_r <= vld_r[head_r];
      rd_idx_r <= head_r;
    end
  end

  assign ring_stat.cell_idx = rd_vld_r ? ram_q : rd_idx_r;
  assign ring_stat.empty    = (count_r == '0);
  assign ring_stat.full     = (count_r == spms_pkg::COUNT_BITS'(spms_pkg::POOL_CELLS));

endmodule

@@ hdl/spms_ctrl.sv @@
// ----------------------------------------------------------------------------
// spms_ctrl
// Request sequencer, stack top registers and the cell memory.
// ----------------------------------------------------------------------------
module spms_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  spms_pkg::in_word_t     in_word,
  output logic                   out_valid,
  output spms_pkg::out_word_t    out_word,
  output spms_pkg::ring_req_t    ring_req,
  input  spms_pkg::ring_stat_t   ring_stat
);

  localparam int CB     = spms_pkg::CELL_BITS;
  localparam int TB     = spms_pkg::TOP_BITS;
  localparam int VB     = spms_pkg::VALUE_BITS;
  localparam int CELL_W = VB + TB;

  spms_pkg::state_t    state_r, state_nxt;
  spms_pkg::in_word_t  req_r, req_nxt;
  logic [TB-1:0]       top_r, top_nxt;
  logic [TB-1:0]       stack_top_r [spms_pkg::NUM_STACKS];
  logic [TB-1:0]       stack_top_nxt [spms_pkg::NUM_STACKS];
  logic                out_valid_r, out_valid_nxt;
  spms_pkg::out_word_t out_word_r, out_word_nxt;

  logic                accept;
  logic [TB-1:0]       sel_top;
  logic                sel_ok;
  logic                top_empty;
  logic                cell_we;
  logic [CB-1:0]       cell_waddr;
  logic [CELL_W-1:0]   cell_wdata;
  logic [CELL_W-1:0]   cell_q;
  logic [VB-1:0]       cell_value;
  logic [TB-1:0]       cell_below;

  assign accept = start && (state_r == spms_pkg::S_IDLE);
  assign busy   = (state_r != spms_pkg::S_IDLE);

  always_comb begin
    sel_top = spms_pkg::NO_CELL;
    for (int i = 0; i < spms_pkg::NUM_STACKS; i++) begin
      if (in_word.stack_select == 2'(i)) begin
        sel_top = stack_top_r[i];
      end
    end
  end

  spms_ram #(
    .WIDTH (CELL_W),
    .DEPTH (spms_pkg::POOL_CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_waddr),
    .wr_data (cell_wdata),
    .rd_en   (accept),
    .rd_addr (sel_top[CB-1:0]),
    .rd_data (cell_q)
  );

  assign cell_value = cell_q[CELL_W-1:TB];
  assign cell_below = cell_q[TB-1:0];
  assign sel_ok     = (req_r.stack_select < 2'(spms_pkg::NUM_STACKS));
  assign top_empty  = (top_r == spms_pkg::NO_CELL);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    top_nxt       = top_r;
    stack_top_nxt = stack_top_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    cell_we       = 1'b0;
    cell_waddr    = ring_stat.cell_idx;
    cell_wdata    = {VB'($unsigned(req_r.push_value)), top_r};
    ring_req      = '0;
    ring_req.give_cell = top_r[CB-1:0];

    case (state_r)
      spms_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt        = in_word;
          top_nxt        = sel_top;
          ring_req.rd_en = 1'b1;
          state_nxt      = spms_pkg::S_EXEC;
        end
      end
      spms_pkg::S_EXEC: begin
        out_valid_nxt           = 1'b1;
        out_word_nxt.status     = spms_pkg::STAT_OK;
        out_word_nxt.read_value = '0;
        out_word_nxt.empty_flag = sel_ok && top_empty;
        if (!sel_ok) begin
          out_word_nxt.status = spms_pkg::STAT_INVALID;
        end else begin
          case (req_r.kind)
            spms_pkg::KIND_PUSH: begin
              if (ring_stat.empty) begin
                out_word_nxt.status = spms_pkg::STAT_FULL;
              end else begin
                ring_req.take = 1'b1;
                cell_we       = 1'b1;
                for (int i = 0; i < spms_pkg::NUM_STACKS; i++) begin
                  if (req_r.stack_select == 2'(i)) begin
                    stack_top_nxt[i] = {1'b0, ring_stat.cell_idx};
                  end
                end
              end
            end
            spms_pkg::KIND_POP: begin
              if (top_empty) begin
                out_word_nxt.status = spms_pkg::STAT_EMPTY;
              end else begin
                out_word_nxt.read_value = spms_pkg::IO_BITS'($signed(cell_value));
                ring_req.give = !ring_stat.full;
                for (int i = 0; i < spms_pkg::NUM_STACKS; i++) begin
                  if (req_r.stack_select == 2'(i)) begin
                    stack_top_nxt[i] = cell_below;
                  end
                end
              end
            end
            spms_pkg::KIND_PEEK: begin
              if (top_empty) begin
                out_word_nxt.status = spms_pkg::STAT_EMPTY;
              end else begin
                out_word_nxt.read_value = spms_pkg::IO_BITS'($signed(cell_value));
              end
            end
            default: begin
            end
          endcase
        end
        state_nxt = spms_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spms_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spms_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < spms_pkg::NUM_STACKS; i++) begin
        stack_top_r[i] <= spms_pkg::NO_CELL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      stack_top_r <= stack_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    top_r      <= top_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ hdl/shared_pool_multi_stack_top.sv @@
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_top: three linked stacks on one shared cell pool.
// Accepted word is registered, then EXEC registers the result strobe.
// A word is taken only while idle; busy spans the cell read-modify-write.
// The receiver cannot stall: each result word is strobed for one cycle.
// Sync active-low reset: stacks empty, free ring full, no memory clearing.
// ----------------------------------------------------------------------------
`include "shared_pool_multi_stack_top_assert.svh"

module shared_pool_multi_stack_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  spms_pkg::in_word_t  in_word,
  output logic                out_valid,
  output spms_pkg::out_word_t out_word
);

  spms_pkg::ring_req_t  ring_req;
  spms_pkg::ring_stat_t ring_stat;

  spms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .ring_req  (ring_req),
    .ring_stat (ring_stat)
  );

  spms_free_ring u_free_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ring_req  (ring_req),
    .ring_stat (ring_stat)
  );

  `SPMS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "accept not held")
  `SPMS_ASSERT_IMP(a_result_idle, out_valid, !busy, "result strobe while busy")
  `SPMS_ASSERT_NOW(a_ring_one_op, !(ring_req.take && ring_req.give), "ring take and give together")
  `SPMS_ASSERT_IMP(a_take_nonempty, ring_req.take, !ring_stat.empty && busy, "take from empty ring")

endmodule
